// File: design/cpr_pkg.sv
// Shared constants, register codes and saturation helpers for the pushback resolver.
package cpr_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_PUSH   = 2'd0,
    CFG_GROUND_MIN = 2'd1,
    CFG_FIX_VEL    = 2'd2
  } cfg_idx_e;

  localparam logic        [30:0] MAX_PUSH_RST   = 31'd65536;
  localparam logic signed [15:0] GROUND_MIN_RST = 16'sd11585;
  localparam logic               FIX_VEL_RST    = 1'b1;

  // 0.001 in Q16.16, nearest
  localparam logic [6:0] PUSH_EPS = 7'd66;

  // first bit weight of the two-bits-per-step square root
  localparam logic [63:0] SQRT_B0 = 64'h4000_0000_0000_0000;

  // highest quotient bit: unit vector (Q1.14) and clamp (below 2^31)
  localparam logic [4:0] UNIT_QMSB  = 5'd14;
  localparam logic [4:0] CLAMP_QMSB = 5'd30;

  localparam logic signed [63:0] SAT48_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] SAT48_LO = -SAT48_HI - 64'sd1;
  localparam logic signed [63:0] SAT32_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT32_LO = -SAT32_HI - 64'sd1;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > SAT48_HI) begin
      return $signed(SAT48_HI[47:0]);
    end else if (v < SAT48_LO) begin
      return $signed(SAT48_LO[47:0]);
    end
    return $signed(v[47:0]);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > SAT32_HI) begin
      return $signed(SAT32_HI[31:0]);
    end else if (v < SAT32_LO) begin
      return $signed(SAT32_LO[31:0]);
    end
    return $signed(v[31:0]);
  endfunction

  function automatic logic [47:0] mag48(input logic signed [47:0] v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

endpackage

// File: design/collision_pushback_resolver.sv
// Collision pushback resolver: contact merge, clamp and velocity fix on one shared datapath.
// A dropped contact needs no arithmetic; after the last contact the frame's word waits in
// ST_OUT until the output register is free, that is not valid or not stalled.
// Throughput: one contact at a time; set by the shared 34x32 multiplier, the one-bit-per-cycle
// restoring divider (15 or 31 steps per component) and the 32-step square root.
// Reset: asynchronous, active low; clears the running push, flags and sequencer, and loads
// the register defaults (max push 1.0, ground 0.707, velocity fix on).
module collision_pushback_resolver (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic signed [31:0] depth_i,
  input  logic               round_shape_i,
  input  logic               last_contact_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] push_x_o,
  output logic signed [31:0] push_y_o,
  output logic signed [31:0] push_z_o,
  output logic signed [31:0] new_vel_x_o,
  output logic signed [31:0] new_vel_y_o,
  output logic signed [31:0] new_vel_z_o,
  output logic               on_ground_o,
  output logic               push_applied_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_P_MUL, ST_P_ACC, ST_SCALE, ST_SQ_MUL, ST_SQ_ACC, ST_SQ_INIT, ST_SQRT,
    ST_LEN_DONE, ST_U_LOAD, ST_DIV, ST_U_DONE, ST_CL_MUL, ST_CL_LOAD, ST_CL_DONE,
    ST_PS_LEN, ST_DOT_MUL, ST_DOT_ACC, ST_PIN, ST_FIX_MUL, ST_FIX_ACC, ST_COMMIT,
    ST_LAST, ST_VD_MUL, ST_VD_ACC, ST_VD_CHK, ST_VF_LO, ST_VF_HI, ST_VF_ACC, ST_OUT
  } state_e;

  // which vector the length routine is working on
  typedef enum logic [1:0] {PH_ADD, PH_SUM, PH_PS} phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [1:0] idx_q, idx_d;

  logic [30:0]        max_q, max_d;
  logic signed [15:0] gmin_q, gmin_d;
  logic               fixv_q, fixv_d;

  logic signed [47:0] sum_q [3];
  logic signed [47:0] sum_d [3];
  logic any_q, any_d, gnd_q, gnd_d;

  logic signed [15:0] n_q [3];
  logic signed [15:0] n_d [3];
  logic signed [31:0] d_q, d_d;
  logic round_q, round_d, last_q, last_d;
  logic signed [31:0] nv_q [3];
  logic signed [31:0] nv_d [3];

  logic signed [47:0] t_q [3];
  logic signed [47:0] t_d [3];
  logic signed [33:0] p_q [3];
  logic signed [33:0] p_d [3];
  logic signed [15:0] u_q [3];
  logic signed [15:0] u_d [3];
  logic [47:0] m_q [3];
  logic [47:0] m_d [3];
  logic [2:0]  sg_q, sg_d;
  logic [4:0]  sh_q, sh_d;
  logic signed [31:0] ps_q [3];
  logic signed [31:0] ps_d [3];

  logic [63:0] sq_q, sq_d;
  logic signed [63:0] dot_q, dot_d;
  logic [63:0] x_q, x_d, r_q, r_d, b_q, b_d;
  logic [31:0] ls_q, ls_d;
  logic [63:0] rem_q, rem_d, dsh_q, dsh_d;
  logic [30:0] q_q, q_d;
  logic [4:0]  cnt_q, cnt_d;
  logic signed [35:0] pin_q, pin_d;
  logic [39:0] lo_q, lo_d;
  logic applied_q, applied_d;

  logic [33:0] ma;
  logic [31:0] mb;
  logic [65:0] prod_q, prod_d;

  logic signed [31:0] opush_q [3];
  logic signed [31:0] opush_d [3];
  logic signed [31:0] ovel_q [3];
  logic signed [31:0] ovel_d [3];
  logic ognd_q, ognd_d, oapp_q, oapp_d, ovalid_q, ovalid_d;

  logic [15:0] n_mag, u_mag;
  logic [33:0] p_mag;
  logic [35:0] pin_mag;
  logic [31:0] v_mag;
  logic [46:0] d_mag;
  logic [48:0] len_w;
  logic        in_acc, cfg_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;

  assign n_mag   = n_q[idx_q][15] ? 16'(-n_q[idx_q]) : 16'(n_q[idx_q]);
  assign u_mag   = u_q[idx_q][15] ? 16'(-u_q[idx_q]) : 16'(u_q[idx_q]);
  assign p_mag   = p_q[idx_q][33] ? 34'(-p_q[idx_q]) : 34'(p_q[idx_q]);
  assign pin_mag = pin_q[35] ? 36'(-pin_q) : 36'(pin_q);
  assign v_mag   = nv_q[idx_q][31] ? 32'(-nv_q[idx_q]) : 32'(nv_q[idx_q]);
  assign d_mag   = 47'(-dot_q);
  assign len_w   = 49'(ls_q) << sh_q;

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      ST_P_MUL: begin
        ma = {18'b0, n_mag};
        mb = d_q[31:0];
      end
      ST_SQ_MUL: begin
        ma = {3'b0, m_q[idx_q][30:0]};
        mb = {1'b0, m_q[idx_q][30:0]};
      end
      ST_CL_MUL: begin
        ma = {3'b0, m_q[idx_q][30:0]};
        mb = {1'b0, max_q};
      end
      ST_DOT_MUL: begin
        ma = {18'b0, u_mag};
        mb = p_mag[31:0];
      end
      ST_FIX_MUL: begin
        ma = pin_mag[33:0];
        mb = {16'b0, u_mag};
      end
      ST_VD_MUL: begin
        ma = {18'b0, u_mag};
        mb = v_mag;
      end
      ST_VF_LO: begin
        ma = {18'b0, u_mag};
        mb = {8'b0, d_mag[23:0]};
      end
      ST_VF_HI: begin
        ma = {18'b0, u_mag};
        mb = {9'b0, d_mag[46:24]};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_d = {32'b0, ma} * {34'b0, mb};

  always_comb begin
    logic [47:0]        rsum;
    logic signed [33:0] p_new;
    logic signed [47:0] t_new;
    logic [63:0]        rb;
    logic               ge;
    logic signed [63:0] prod64;
    logic signed [63:0] delta;
    logic [63:0]        dm;
    logic [63:0]        rm;
    logic signed [63:0] corr;
    logic               pin_lt;
    logic [63:0]        total;

    rsum   = '0;
    p_new  = '0;
    t_new  = '0;
    rb     = '0;
    ge     = 1'b0;
    prod64 = $signed(prod_q[63:0]);
    delta  = '0;
    dm     = '0;
    rm     = '0;
    corr   = '0;
    pin_lt = 1'b0;
    total  = '0;

    state_d   = state_q;
    phase_d   = phase_q;
    idx_d     = idx_q;
    max_d     = max_q;
    gmin_d    = gmin_q;
    fixv_d    = fixv_q;
    sum_d     = sum_q;
    any_d     = any_q;
    gnd_d     = gnd_q;
    n_d       = n_q;
    d_d       = d_q;
    round_d   = round_q;
    last_d    = last_q;
    nv_d      = nv_q;
    t_d       = t_q;
    p_d       = p_q;
    u_d       = u_q;
    m_d       = m_q;
    sg_d      = sg_q;
    sh_d      = sh_q;
    ps_d      = ps_q;
    sq_d      = sq_q;
    dot_d     = dot_q;
    x_d       = x_q;
    r_d       = r_q;
    b_d       = b_q;
    ls_d      = ls_q;
    rem_d     = rem_q;
    dsh_d     = dsh_q;
    q_d       = q_q;
    cnt_d     = cnt_q;
    pin_d     = pin_q;
    lo_d      = lo_q;
    applied_d = applied_q;
    opush_d   = opush_q;
    ovel_d    = ovel_q;
    ognd_d    = ognd_q;
    oapp_d    = oapp_q;
    ovalid_d  = ovalid_q && out_stall_i;

    if (cfg_acc) begin
      case (cpr_pkg::cfg_idx_e'(cfg_index_i))
        cpr_pkg::CFG_MAX_PUSH:   max_d  = cfg_data_i[30:0];
        cpr_pkg::CFG_GROUND_MIN: gmin_d = $signed(cfg_data_i[15:0]);
        cpr_pkg::CFG_FIX_VEL:    fixv_d = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          n_d[0]  = normal_x_i;
          n_d[1]  = normal_y_i;
          n_d[2]  = normal_z_i;
          d_d     = depth_i;
          round_d = round_shape_i;
          last_d  = last_contact_i;
          nv_d[0] = vel_x_i;
          nv_d[1] = vel_y_i;
          nv_d[2] = vel_z_i;
          idx_d   = 2'd0;
          if (depth_i > 32'sd0) begin
            state_d = ST_P_MUL;
          end else if (last_contact_i) begin
            state_d = ST_LAST;
          end
        end
      end

      ST_P_MUL: state_d = ST_P_ACC;

      ST_P_ACC: begin
        // p = round(n * depth / 2^14), then tentative sum
        rsum = prod_q[47:0] + 48'h2000;
        p_new = n_q[idx_q][15] ? -$signed({1'b0, rsum[46:14]}) : $signed({1'b0, rsum[46:14]});
        t_new = cpr_pkg::sat48(64'(sum_q[idx_q]) + 64'(p_new));
        p_d[idx_q]  = p_new;
        t_d[idx_q]  = t_new;
        m_d[idx_q]  = cpr_pkg::mag48(t_new);
        sg_d[idx_q] = t_new[47];
        if (idx_q == 2'd2) begin
          sh_d    = '0;
          phase_d = PH_ADD;
          state_d = ST_SCALE;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_P_MUL;
        end
      end

      ST_SCALE: begin
        if ((|m_q[0][47:31]) || (|m_q[1][47:31]) || (|m_q[2][47:31])) begin
          m_d[0] = m_q[0] >> 1;
          m_d[1] = m_q[1] >> 1;
          m_d[2] = m_q[2] >> 1;
          sh_d   = sh_q + 5'd1;
        end else begin
          sq_d    = '0;
          idx_d   = 2'd0;
          state_d = ST_SQ_MUL;
        end
      end

      ST_SQ_MUL: state_d = ST_SQ_ACC;

      ST_SQ_ACC: begin
        sq_d = sq_q + prod_q[63:0];
        if (idx_q == 2'd2) begin
          state_d = ST_SQ_INIT;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_SQ_MUL;
        end
      end

      ST_SQ_INIT: begin
        x_d     = sq_q;
        r_d     = '0;
        b_d     = cpr_pkg::SQRT_B0;
        state_d = ST_SQRT;
      end

      ST_SQRT: begin
        rb = r_q + b_q;
        if (x_q >= rb) begin
          x_d = x_q - rb;
          r_d = (r_q >> 1) + b_q;
        end else begin
          r_d = r_q >> 1;
        end
        b_d = b_q >> 2;
        if (b_q == 64'd1) begin
          ls_d    = r_d[31:0];
          state_d = ST_LEN_DONE;
        end
      end

      ST_LEN_DONE: begin
        idx_d = 2'd0;
        case (phase_q)
          PH_ADD: state_d = ST_U_LOAD;
          PH_SUM: begin
            if (len_w > {18'b0, max_q}) begin
              state_d = ST_CL_MUL;
            end else begin
              ps_d[0] = sum_q[0][31:0];
              ps_d[1] = sum_q[1][31:0];
              ps_d[2] = sum_q[2][31:0];
              state_d = ST_PS_LEN;
            end
          end
          PH_PS: begin
            if (len_w >= 49'(cpr_pkg::PUSH_EPS)) begin
              applied_d = 1'b1;
              state_d   = fixv_q ? ST_U_LOAD : ST_OUT;
            end else begin
              ps_d[0] = '0;
              ps_d[1] = '0;
              ps_d[2] = '0;
              state_d = ST_OUT;
            end
          end
          default: state_d = ST_OUT;
        endcase
      end

      ST_U_LOAD: begin
        q_d = '0;
        if (ls_q == '0) begin
          // zero-length vector has a zero unit vector
          state_d = ST_U_DONE;
        end else begin
          rem_d   = {19'b0, m_q[idx_q][30:0], 14'b0} + {33'b0, ls_q[31:1]};
          dsh_d   = {18'b0, ls_q, 14'b0};
          cnt_d   = cpr_pkg::UNIT_QMSB;
          state_d = ST_DIV;
        end
      end

      ST_DIV: begin
        ge    = rem_q >= dsh_q;
        rem_d = ge ? rem_q - dsh_q : rem_q;
        q_d   = {q_q[29:0], ge};
        dsh_d = dsh_q >> 1;
        if (cnt_q == '0) begin
          state_d = (phase_q == PH_SUM) ? ST_CL_DONE : ST_U_DONE;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end

      ST_U_DONE: begin
        u_d[idx_q] = sg_q[idx_q] ? -$signed({1'b0, q_q[14:0]}) : $signed({1'b0, q_q[14:0]});
        if (idx_q == 2'd2) begin
          idx_d   = 2'd0;
          dot_d   = '0;
          state_d = (phase_q == PH_ADD) ? ST_DOT_MUL : ST_VD_MUL;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_U_LOAD;
        end
      end

      ST_CL_MUL: state_d = ST_CL_LOAD;

      ST_CL_LOAD: begin
        q_d     = '0;
        rem_d   = prod_q[63:0] + {33'b0, ls_q[31:1]};
        dsh_d   = {2'b0, ls_q, 30'b0};
        cnt_d   = cpr_pkg::CLAMP_QMSB;
        state_d = ST_DIV;
      end

      ST_CL_DONE: begin
        ps_d[idx_q] = sg_q[idx_q] ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
        if (idx_q == 2'd2) begin
          state_d = ST_PS_LEN;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_CL_MUL;
        end
      end

      ST_PS_LEN: begin
        for (int i = 0; i < 3; i++) begin
          m_d[i]  = cpr_pkg::mag48(48'(ps_q[i]));
          sg_d[i] = ps_q[i][31];
        end
        sh_d    = '0;
        phase_d = PH_PS;
        state_d = ST_SCALE;
      end

      ST_DOT_MUL: state_d = ST_DOT_ACC;

      ST_DOT_ACC: begin
        delta = (u_q[idx_q][15] ^ p_q[idx_q][33]) ? -prod64 : prod64;
        dot_d = dot_q + delta;
        if (idx_q == 2'd2) begin
          state_d = ST_PIN;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_DOT_MUL;
        end
      end

      ST_PIN: begin
        // push along the running direction, taken before the sphere rule
        dm    = dot_q[63] ? 64'(-dot_q) : 64'(dot_q);
        rm    = (dm + 64'h2000) >> 14;
        pin_d = dot_q[63] ? -$signed(rm[35:0]) : $signed(rm[35:0]);
        if (round_q) begin
          u_d[1] = '0;
          p_d[1] = '0;
        end
        idx_d   = 2'd0;
        state_d = ST_FIX_MUL;
      end

      ST_FIX_MUL: state_d = ST_FIX_ACC;

      ST_FIX_ACC: begin
        rm     = (prod_q[63:0] + 64'h2000) >> 14;
        corr   = (pin_q[35] ^ u_q[idx_q][15]) ? -$signed(rm) : $signed(rm);
        pin_lt = 64'(pin_q) < $signed({15'b0, len_w});
        if (pin_lt) begin
          t_d[idx_q] = cpr_pkg::sat48(64'(t_q[idx_q]) + 64'(p_q[idx_q]) - corr);
        end else begin
          t_d[idx_q] = cpr_pkg::sat48(64'(p_q[idx_q]));
        end
        if (idx_q == 2'd2) begin
          state_d = ST_COMMIT;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_FIX_MUL;
        end
      end

      ST_COMMIT: begin
        sum_d = t_q;
        any_d = 1'b1;
        if (n_q[1] >= gmin_q) begin
          gnd_d = 1'b1;
        end
        state_d = last_q ? ST_LAST : ST_IDLE;
      end

      ST_LAST: begin
        ps_d[0]   = '0;
        ps_d[1]   = '0;
        ps_d[2]   = '0;
        applied_d = 1'b0;
        if (any_q) begin
          for (int i = 0; i < 3; i++) begin
            m_d[i]  = cpr_pkg::mag48(sum_q[i]);
            sg_d[i] = sum_q[i][47];
          end
          sh_d    = '0;
          phase_d = PH_SUM;
          state_d = ST_SCALE;
        end else begin
          state_d = ST_OUT;
        end
      end

      ST_VD_MUL: state_d = ST_VD_ACC;

      ST_VD_ACC: begin
        delta = (u_q[idx_q][15] ^ nv_q[idx_q][31]) ? -prod64 : prod64;
        dot_d = dot_q + delta;
        if (idx_q == 2'd2) begin
          state_d = ST_VD_CHK;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_VD_MUL;
        end
      end

      ST_VD_CHK: begin
        idx_d   = 2'd0;
        state_d = dot_q[63] ? ST_VF_LO : ST_OUT;
      end

      ST_VF_LO: state_d = ST_VF_HI;

      ST_VF_HI: begin
        lo_d    = prod_q[39:0];
        state_d = ST_VF_ACC;
      end

      ST_VF_ACC: begin
        // un * D from two partial products, D known negative here
        total = (prod_q[63:0] << 24) + {24'b0, lo_q};
        rm    = (total + 64'h0800_0000) >> 28;
        corr  = u_q[idx_q][15] ? $signed(rm) : -$signed(rm);
        nv_d[idx_q] = cpr_pkg::sat32(64'(nv_q[idx_q]) - corr);
        if (idx_q == 2'd2) begin
          state_d = ST_OUT;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_VF_LO;
        end
      end

      ST_OUT: begin
        if (!ovalid_q || !out_stall_i) begin
          opush_d  = ps_q;
          ovel_d   = nv_q;
          ognd_d   = gnd_q;
          oapp_d   = applied_q;
          ovalid_d = 1'b1;
          sum_d[0] = '0;
          sum_d[1] = '0;
          sum_d[2] = '0;
          any_d    = 1'b0;
          gnd_d    = 1'b0;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_ADD;
      idx_q     <= '0;
      max_q     <= cpr_pkg::MAX_PUSH_RST;
      gmin_q    <= cpr_pkg::GROUND_MIN_RST;
      fixv_q    <= cpr_pkg::FIX_VEL_RST;
      any_q     <= 1'b0;
      gnd_q     <= 1'b0;
      d_q       <= '0;
      round_q   <= 1'b0;
      last_q    <= 1'b0;
      sg_q      <= '0;
      sh_q      <= '0;
      sq_q      <= '0;
      dot_q     <= '0;
      x_q       <= '0;
      r_q       <= '0;
      b_q       <= '0;
      ls_q      <= '0;
      rem_q     <= '0;
      dsh_q     <= '0;
      q_q       <= '0;
      cnt_q     <= '0;
      pin_q     <= '0;
      lo_q      <= '0;
      applied_q <= 1'b0;
      prod_q    <= '0;
      ognd_q    <= 1'b0;
      oapp_q    <= 1'b0;
      ovalid_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i]   <= '0;
        n_q[i]     <= '0;
        nv_q[i]    <= '0;
        t_q[i]     <= '0;
        p_q[i]     <= '0;
        u_q[i]     <= '0;
        m_q[i]     <= '0;
        ps_q[i]    <= '0;
        opush_q[i] <= '0;
        ovel_q[i]  <= '0;
      end
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      max_q     <= max_d;
      gmin_q    <= gmin_d;
      fixv_q    <= fixv_d;
      sum_q     <= sum_d;
      any_q     <= any_d;
      gnd_q     <= gnd_d;
      n_q       <= n_d;
      d_q       <= d_d;
      round_q   <= round_d;
      last_q    <= last_d;
      nv_q      <= nv_d;
      t_q       <= t_d;
      p_q       <= p_d;
      u_q       <= u_d;
      m_q       <= m_d;
      sg_q      <= sg_d;
      sh_q      <= sh_d;
      ps_q      <= ps_d;
      sq_q      <= sq_d;
      dot_q     <= dot_d;
      x_q       <= x_d;
      r_q       <= r_d;
      b_q       <= b_d;
      ls_q      <= ls_d;
      rem_q     <= rem_d;
      dsh_q     <= dsh_d;
      q_q       <= q_d;
      cnt_q     <= cnt_d;
      pin_q     <= pin_d;
      lo_q      <= lo_d;
      applied_q <= applied_d;
      prod_q    <= prod_d;
      opush_q   <= opush_d;
      ovel_q    <= ovel_d;
      ognd_q    <= ognd_d;
      oapp_q    <= oapp_d;
      ovalid_q  <= ovalid_d;
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = ovalid_q;
  assign push_x_o       = opush_q[0];
  assign push_y_o       = opush_q[1];
  assign push_z_o       = opush_q[2];
  assign new_vel_x_o    = ovel_q[0];
  assign new_vel_y_o    = ovel_q[1];
  assign new_vel_z_o    = ovel_q[2];
  assign on_ground_o    = ognd_q;
  assign push_applied_o = oapp_q;

  // a negligible push is reported as zero
  a_zero_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !push_applied_o |->
      (push_x_o == 32'sd0) && (push_y_o == 32'sd0) && (push_z_o == 32'sd0))
    else $error("push word nonzero without push_applied");

  // magnitudes are below 2^48, so scaling never needs more than 17 shifts
  a_shift_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sh_q <= 5'd17)
    else $error("length scaling shift out of range");

  // the divider ends with a remainder below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && (cnt_q == 5'd0) |=> rem_q < {32'b0, ls_q})
    else $error("divider remainder not below divisor");

endmodule
